### hw/rtl/csc_pkg.sv
// ----------------------------------------------------------------------------
// csc_pkg: capsule segment coverage shared definitions
// Widths of the fixed-point datapath, register indexes and the job record
// handed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  // Field widths
  localparam int LOC_W      = 8;
  localparam int ALPHA_W    = 8;
  localparam int COORD_W    = 24;
  localparam int EDGE_W     = 24;
  localparam int ORG_W      = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  // Fixed-point formats
  localparam int FRAC_BITS  = 8;
  localparam int PROJ_BITS  = 16;
  localparam int HALF       = 1 << (FRAC_BITS - 1);
  localparam int PROJ_HALF  = 1 << (PROJ_BITS - 1);
  localparam int T_ONE      = 1 << PROJ_BITS;
  localparam int COV_MAX    = 1 << FRAC_BITS;
  localparam int ALPHA_MAX  = (1 << ALPHA_W) - 1;

  // Datapath widths
  localparam int V_W     = 26;                 // pixel centre minus start
  localparam int D_W     = COORD_W + 1;        // end minus start
  localparam int PROD_W  = V_W + D_W;          // one dot product term
  localparam int DOT_W   = PROD_W + 1;
  localparam int LEN2_W  = 49;                 // |D|^2 < 2^49
  localparam int T_W     = PROJ_BITS + 1;      // 0 .. 65536
  localparam int TD_W    = V_W + PROJ_BITS + 1;
  localparam int E_W     = TD_W - PROJ_BITS;
  localparam int ROOT_W  = E_W;
  localparam int SQ_W    = 2 * ROOT_W;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_START_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_END_X      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_END_Y      = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_OUTER = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = CFG_IDX_W'(6);

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic        [EDGE_W-1:0]  edge_outer;
    logic signed [ORG_W-1:0]   origin_x;
    logic signed [ORG_W-1:0]   origin_y;
  } cfg_t;

  // How the projection parameter is found
  typedef enum logic [1:0] {
    PROJ_START,   // closest point is the start point
    PROJ_END,     // closest point is the end point
    PROJ_DIV      // interior: t = dot / len2
  } proj_e;

  typedef struct packed {
    logic signed [V_W-1:0]    vx;
    logic signed [V_W-1:0]    vy;
    logic signed [D_W-1:0]    dx;
    logic signed [D_W-1:0]    dy;
    logic        [LEN2_W-1:0] dot;
    logic        [LEN2_W-1:0] len2;
    proj_e                    proj;
    logic        [ALPHA_W-1:0] old_alpha;
  } job_t;

endpackage

`default_nettype wire

### hw/rtl/csc_if.sv
// ----------------------------------------------------------------------------
// csc_if: capsule segment coverage channel interfaces
// Pixel input, alpha output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_pix_if;
  logic                         valid;
  logic                         ready;
  logic [csc_pkg::LOC_W-1:0]    local_x;
  logic [csc_pkg::LOC_W-1:0]    local_y;
  logic [csc_pkg::ALPHA_W-1:0]  old_alpha;
  modport source (output valid, output local_x, output local_y, output old_alpha,
                  input ready);
  modport sink   (input valid, input local_x, input local_y, input old_alpha,
                  output ready);
endinterface

interface csc_alpha_if;
  logic                         valid;
  logic                         ready;
  logic [csc_pkg::ALPHA_W-1:0]  new_alpha;
  modport source (output valid, output new_alpha, input ready);
  modport sink   (input valid, input new_alpha, output ready);
endinterface

interface csc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [csc_pkg::CFG_IDX_W-1:0]  index;
  logic [csc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/csc_front.sv
// ----------------------------------------------------------------------------
// csc_front: register file, vector setup and projection classification
// Forms V and D, the dot products, and sorts each item into start, end or
// divide before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  csc_pix_if.sink         pix_i,
  csc_cfg_if.sink         cfg_i,
  output csc_pkg::cfg_t   cfg_o,
  output logic            push_o,
  output csc_pkg::job_t   job_o,
  input  logic            full_i
);
  import csc_pkg::*;

  cfg_t cfg_q;

  logic adv;

  // stage A: V and D
  logic                     a_vld_q;
  logic signed [V_W-1:0]    a_vx_q, a_vy_q, a_vx_d, a_vy_d;
  logic signed [D_W-1:0]    a_dx_q, a_dy_q, a_dx_d, a_dy_d;
  logic [ALPHA_W-1:0]       a_old_q;
  // stage B: products
  logic                     b_vld_q;
  logic signed [PROD_W-1:0] b_pxd_q, b_pyd_q, b_sxx_q, b_syy_q;
  logic signed [V_W-1:0]    b_vx_q, b_vy_q;
  logic signed [D_W-1:0]    b_dx_q, b_dy_q;
  logic [ALPHA_W-1:0]       b_old_q;
  // stage C: sums
  logic                     c_vld_q;
  logic signed [DOT_W-1:0]  c_dot_q;
  logic [LEN2_W-1:0]        c_len2_q;
  logic signed [V_W-1:0]    c_vx_q, c_vy_q;
  logic signed [D_W-1:0]    c_dx_q, c_dy_q;
  logic [ALPHA_W-1:0]       c_old_q;

  logic signed [V_W-1:0] cx, cy, px, py;
  logic dot_pos, dot_ge;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_START_X:    cfg_q.start_x    <= cfg_i.data[COORD_W-1:0];
        REG_START_Y:    cfg_q.start_y    <= cfg_i.data[COORD_W-1:0];
        REG_END_X:      cfg_q.end_x      <= cfg_i.data[COORD_W-1:0];
        REG_END_Y:      cfg_q.end_y      <= cfg_i.data[COORD_W-1:0];
        REG_EDGE_OUTER: cfg_q.edge_outer <= cfg_i.data[EDGE_W-1:0];
        REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_i.data[ORG_W-1:0];
        REG_ORIGIN_Y:   cfg_q.origin_y   <= cfg_i.data[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel centre: ((origin + local) << FRAC) + half, fits V_W signed
  always_comb begin
    cx = V_W'(cfg_q.origin_x) + $signed({{(V_W-LOC_W){1'b0}}, pix_i.local_x});
    cy = V_W'(cfg_q.origin_y) + $signed({{(V_W-LOC_W){1'b0}}, pix_i.local_y});
    px = (cx <<< FRAC_BITS) + V_W'(HALF);
    py = (cy <<< FRAC_BITS) + V_W'(HALF);
    a_vx_d = px - V_W'(cfg_q.start_x);
    a_vy_d = py - V_W'(cfg_q.start_y);
    a_dx_d = D_W'(cfg_q.end_x) - D_W'(cfg_q.start_x);
    a_dy_d = D_W'(cfg_q.end_y) - D_W'(cfg_q.start_y);
  end

  assign adv         = !c_vld_q || !full_i;
  assign pix_i.ready = adv;
  assign push_o      = c_vld_q && !full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= pix_i.valid;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_vx_q  <= a_vx_d;
      a_vy_q  <= a_vy_d;
      a_dx_q  <= a_dx_d;
      a_dy_q  <= a_dy_d;
      a_old_q <= pix_i.old_alpha;

      b_pxd_q <= a_vx_q * a_dx_q;
      b_pyd_q <= a_vy_q * a_dy_q;
      b_sxx_q <= a_dx_q * a_dx_q;
      b_syy_q <= a_dy_q * a_dy_q;
      b_vx_q  <= a_vx_q;
      b_vy_q  <= a_vy_q;
      b_dx_q  <= a_dx_q;
      b_dy_q  <= a_dy_q;
      b_old_q <= a_old_q;

      c_dot_q  <= DOT_W'(b_pxd_q) + DOT_W'(b_pyd_q);
      c_len2_q <= LEN2_W'(b_sxx_q) + LEN2_W'(b_syy_q);
      c_vx_q   <= b_vx_q;
      c_vy_q   <= b_vy_q;
      c_dx_q   <= b_dx_q;
      c_dy_q   <= b_dy_q;
      c_old_q  <= b_old_q;
    end
  end

  assign dot_pos = !c_dot_q[DOT_W-1] && (c_dot_q != '0);
  assign dot_ge  = c_dot_q >= $signed({{(DOT_W-LEN2_W){1'b0}}, c_len2_q});

  always_comb begin
    job_o.vx        = c_vx_q;
    job_o.vy        = c_vy_q;
    job_o.dx        = c_dx_q;
    job_o.dy        = c_dy_q;
    job_o.dot       = c_dot_q[LEN2_W-1:0];
    job_o.len2      = c_len2_q;
    job_o.old_alpha = c_old_q;
    if ((c_len2_q == '0) || !dot_pos) begin
      job_o.proj = PROJ_START;
    end else if (dot_ge) begin
      job_o.proj = PROJ_END;
    end else begin
      job_o.proj = PROJ_DIV;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/csc_fifo.sv
// ----------------------------------------------------------------------------
// csc_fifo: job queue between front and back end
// Small register queue, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  csc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output csc_pkg::job_t job_o
);
  import csc_pkg::*;

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign full_o  = (count_q == (PTR_W+1)'(FIFO_DEPTH));
  assign empty_o = (count_q == '0);
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      if (push_i && !pop_i)      count_q <= count_q + (PTR_W+1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PTR_W+1)'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + (PTR_W+1)'(1))
    else $error("queue count did not grow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (PTR_W+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

### hw/rtl/csc_back.sv
// ----------------------------------------------------------------------------
// csc_back: projection, distance and alpha pipeline
// Restoring divide for t, closest-point offset, squared distance, digit
// square root, coverage clamp and max merge into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csc_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  csc_pkg::cfg_t cfg_i,
  input  logic          avail_i,
  input  csc_pkg::job_t job_i,
  output logic          pop_o,
  csc_alpha_if.source   alpha_o
);
  import csc_pkg::*;

  localparam int DIV_STAGES  = PROJ_BITS;
  localparam int SQRT_STAGES = ROOT_W;

  typedef struct packed {
    job_t                 job;
    logic [LEN2_W-1:0]    rem;
    logic [PROJ_BITS-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [SQ_W-1:0]    n;
    logic [ROOT_W+1:0]  rem;
    logic [ROOT_W-1:0]  root;
    logic [ALPHA_W-1:0] old_alpha;
  } sqrt_t;

  function automatic div_t div_step(div_t s);
    div_t             r;
    logic [LEN2_W:0]  sh;
    r  = s;
    sh = {s.rem, 1'b0};
    if (sh >= {1'b0, s.job.len2}) begin
      r.rem = LEN2_W'(sh - {1'b0, s.job.len2});
      r.quo = {s.quo[PROJ_BITS-2:0], 1'b1};
    end else begin
      r.rem = sh[LEN2_W-1:0];
      r.quo = {s.quo[PROJ_BITS-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic sqrt_t sqrt_step(sqrt_t s);
    sqrt_t             r;
    logic [ROOT_W+1:0] rs, trial;
    r     = s;
    rs    = {s.rem[ROOT_W-1:0], s.n[SQ_W-1 -: 2]};
    trial = {s.root, 2'b01};
    if (rs >= trial) begin
      r.rem  = rs - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = rs;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.n = {s.n[SQ_W-3:0], 2'b00};
    return r;
  endfunction

  logic adv;

  // divider
  div_t div_in;
  div_t div_q [DIV_STAGES];
  div_t div_d [DIV_STAGES];
  logic [DIV_STAGES-1:0] div_vld_q;

  // offset from closest point
  logic                    m_vld_q;
  logic signed [TD_W-1:0]  m_vxs_q, m_vys_q, m_tdx_q, m_tdy_q;
  logic [ALPHA_W-1:0]      m_old_q;
  logic [T_W-1:0]          t_fin;
  div_t                    div_last;

  logic                    r_vld_q;
  logic signed [E_W-1:0]   r_ex_q, r_ey_q;
  logic [ALPHA_W-1:0]      r_old_q;
  logic signed [TD_W-1:0]  ex_full, ey_full;

  logic                    q_vld_q;
  logic [SQ_W-1:0]         q_ex2_q, q_ey2_q;
  logic [ALPHA_W-1:0]      q_old_q;

  // square root
  sqrt_t sq_in;
  sqrt_t sq_q [SQRT_STAGES];
  sqrt_t sq_d [SQRT_STAGES];
  logic                   s_vld_q;
  logic [SQRT_STAGES-1:0] sq_vld_q;

  // coverage and output
  logic                      v_vld_q;
  logic [FRAC_BITS:0]        v_cov_q, cov_d;
  logic [ALPHA_W-1:0]        v_old_q;
  logic signed [ROOT_W+1:0]  cov_raw;
  logic [FRAC_BITS+ALPHA_W:0] scaled;
  logic [ALPHA_W-1:0]        alpha, o_alpha_q;
  logic                      o_vld_q;

  assign adv   = !o_vld_q || alpha_o.ready;
  assign pop_o = adv && avail_i;

  always_comb begin
    div_in.job = job_i;
    div_in.rem = job_i.dot;
    div_in.quo = '0;
    for (int i = 0; i < DIV_STAGES; i++) begin
      div_d[i] = div_step((i == 0) ? div_in : div_q[(i == 0) ? 0 : i-1]);
    end
  end

  assign div_last = div_q[DIV_STAGES-1];

  always_comb begin
    case (div_last.job.proj)
      PROJ_START: t_fin = '0;
      PROJ_END:   t_fin = T_W'(T_ONE);
      PROJ_DIV:   t_fin = {1'b0, div_last.quo};
      default:    t_fin = '0;
    endcase
  end

  always_comb begin
    ex_full = m_vxs_q - m_tdx_q + TD_W'(PROJ_HALF);
    ey_full = m_vys_q - m_tdy_q + TD_W'(PROJ_HALF);
  end

  always_comb begin
    sq_in.n         = q_ex2_q + q_ey2_q;
    sq_in.rem       = '0;
    sq_in.root      = '0;
    sq_in.old_alpha = q_old_q;
  end

  // sq_q[0] holds the sum; stages 1.. iterate
  always_comb begin
    sq_d[0] = sq_in;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sq_d[i] = sqrt_step(sq_q[i-1]);
    end
  end

  always_comb begin
    sqrt_t fin;
    fin     = sqrt_step(sq_q[SQRT_STAGES-1]);
    cov_raw = $signed({{(ROOT_W+2-EDGE_W){1'b0}}, cfg_i.edge_outer})
            - $signed({2'b00, fin.root});
    if (cov_raw[ROOT_W+1]) begin
      cov_d = '0;
    end else if (cov_raw > $signed((ROOT_W+2)'(COV_MAX))) begin
      cov_d = (FRAC_BITS+1)'(COV_MAX);
    end else begin
      cov_d = cov_raw[FRAC_BITS:0];
    end
  end

  always_comb begin
    scaled = {{ALPHA_W{1'b0}}, v_cov_q} * (FRAC_BITS+ALPHA_W+1)'(ALPHA_MAX)
           + (FRAC_BITS+ALPHA_W+1)'(HALF);
    alpha  = scaled[FRAC_BITS+ALPHA_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q <= '0;
      m_vld_q   <= 1'b0;
      r_vld_q   <= 1'b0;
      q_vld_q   <= 1'b0;
      s_vld_q   <= 1'b0;
      sq_vld_q  <= '0;
      v_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
    end else if (adv) begin
      div_vld_q <= {div_vld_q[DIV_STAGES-2:0], avail_i};
      m_vld_q   <= div_vld_q[DIV_STAGES-1];
      r_vld_q   <= m_vld_q;
      q_vld_q   <= r_vld_q;
      s_vld_q   <= q_vld_q;
      sq_vld_q  <= {sq_vld_q[SQRT_STAGES-2:0], q_vld_q};
      v_vld_q   <= sq_vld_q[SQRT_STAGES-1];
      o_vld_q   <= v_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q <= div_d;

      m_tdx_q <= $signed({1'b0, t_fin}) * div_last.job.dx;
      m_tdy_q <= $signed({1'b0, t_fin}) * div_last.job.dy;
      m_vxs_q <= {div_last.job.vx[V_W-1], div_last.job.vx, {PROJ_BITS{1'b0}}};
      m_vys_q <= {div_last.job.vy[V_W-1], div_last.job.vy, {PROJ_BITS{1'b0}}};
      m_old_q <= div_last.job.old_alpha;

      r_ex_q  <= ex_full[TD_W-1:PROJ_BITS];
      r_ey_q  <= ey_full[TD_W-1:PROJ_BITS];
      r_old_q <= m_old_q;

      q_ex2_q <= r_ex_q * r_ex_q;
      q_ey2_q <= r_ey_q * r_ey_q;
      q_old_q <= r_old_q;

      sq_q    <= sq_d;

      v_cov_q <= cov_d;
      v_old_q <= sq_q[SQRT_STAGES-1].old_alpha;

      o_alpha_q <= (v_old_q > alpha) ? v_old_q : alpha;
    end
  end

  assign alpha_o.valid     = o_vld_q;
  assign alpha_o.new_alpha = o_alpha_q;

  // s_vld_q marks the sum stage held in sq_q[0]
  a_sum_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld_q == sq_vld_q[0]) else $error("sqrt entry valid mismatch");
  a_pop_gated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> adv) else $error("pop while pipeline stalled");
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(o_vld_q) |-> $past(v_vld_q)) else $error("result without item");

endmodule

`default_nettype wire

### hw/rtl/capsule_segment_coverage_core.sv
// ----------------------------------------------------------------------------
// capsule_segment_coverage_core: antialiased capsule coverage per pixel
// Projects each pixel centre onto the configured segment, measures the
// distance to the closest point and merges the coverage alpha into the mask.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake     payload
//  pix_i    in   valid/ready   local_x[7:0], local_y[7:0], old_alpha[7:0]
//  alpha_o  out  valid/ready   new_alpha[7:0]
//  cfg_i    in   valid/ready   index[7:0], data[23:0]  (ready tied high)
//
//  One item per cycle sustained while the output is not stalled. The path
//  runs through 3 front stages, the queue register, 16 divide stages,
//  3 offset/square stages, 27 square-root stages (sum plus 26 digit
//  steps), one coverage stage and the output register: 52 register
//  stages in all.
//  Reset clears the registers to zero and empties every stage.
//  A stalled output holds the back end; the 4-entry queue lets the front
//  keep taking items until it fills.
//
`default_nettype none

module capsule_segment_coverage_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  csc_pix_if.sink     pix_i,
  csc_alpha_if.source alpha_o,
  csc_cfg_if.sink     cfg_i
);
  import csc_pkg::*;

  cfg_t cfg;
  logic push, full, pop, empty;
  job_t job_in, job_out;

  // front end: registers, V/D setup, dot and len2, projection class
  csc_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg),
    .push_o (push),
    .job_o  (job_in),
    .full_i (full)
  );

  // decoupling queue
  csc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .job_o   (job_out)
  );

  // back end: divide, offset, distance, coverage, merge
  csc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .avail_i (!empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .alpha_o (alpha_o)
  );

endmodule

`default_nettype wire

### bench/tb_capsule_segment_coverage_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_capsule_segment_coverage_core: self-checking bench for the capsule core
// Streams pixels through the core under several segment settings. The bench
// predicts every output alpha from its own fixed-point capsule math and
// checks the output items in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------

module tb_capsule_segment_coverage_core;
  import csc_pkg::*;

  logic clk_i;
  logic rst_ni;

  csc_pix_if   pix();
  csc_alpha_if alpha();
  csc_cfg_if   cfg();

  capsule_segment_coverage_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix),
    .alpha_o (alpha),
    .cfg_i   (cfg)
  );

  // Idle modes for the phases
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct packed {
    logic [LOC_W-1:0]   lx;
    logic [LOC_W-1:0]   ly;
    logic [ALPHA_W-1:0] old_a;
  } pixel_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;   // the core has 52 register stages
  localparam int HOLD_CYCLES    = 400;

  pixel_t             pix_pending_q[$];
  logic [ALPHA_W-1:0] alpha_expected_q[$];

  // Segment settings as the core should hold them
  longint seg_sx, seg_sy, seg_ex, seg_ey, seg_edge, tile_ox, tile_oy;

  idle_e  idle_mode;
  int     idle_pct;
  int     hold_token, hold_seen, hold_left;
  int     fail_count;
  int     pixels_sent, alphas_checked, nonzero_cov, stalled_cycles;
  int     quiet_cycles;

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // Capsule coverage, same fixed-point steps as the core is meant to take
  function automatic longint clamp_offset(longint v);
    longint lim;
    lim = (longint'(1) << 25) - 1;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [ALPHA_W-1:0] capsule_alpha(pixel_t p);
    longint px, py, dx, dy, vx, vy, len2, dot, t, r, ex, ey, cov, a;
    longint unsigned dist_fx;
    px = (tile_ox + p.lx) * (1 << FRAC_BITS) + HALF;
    py = (tile_oy + p.ly) * (1 << FRAC_BITS) + HALF;
    dx = seg_ex - seg_sx;
    dy = seg_ey - seg_sy;
    vx = clamp_offset(px - seg_sx);
    vy = clamp_offset(py - seg_sy);
    len2 = dx * dx + dy * dy;
    dot = vx * dx + vy * dy;
    t = 0;
    // zero-length segment or behind the start keeps t at zero
    if (len2 > 0 && dot > 0) begin
      if (dot >= len2) begin
        t = T_ONE;
      end else begin
        r = dot;
        for (int i = 0; i < PROJ_BITS; i++) begin
          r = r * 2;
          t = t * 2;
          if (r >= len2) begin
            r = r - len2;
            t = t + 1;
          end
        end
      end
    end
    ex = (vx * T_ONE - t * dx + PROJ_HALF) >>> PROJ_BITS;
    ey = (vy * T_ONE - t * dy + PROJ_HALF) >>> PROJ_BITS;
    dist_fx = int_sqrt(longint'(ex * ex) + longint'(ey * ey));
    cov = seg_edge - longint'(dist_fx);
    if (cov < 0) cov = 0;
    if (cov > COV_MAX) cov = COV_MAX;
    a = (cov * ALPHA_MAX + HALF) >> FRAC_BITS;
    if (a > ALPHA_MAX) a = ALPHA_MAX;
    if (a > 0) nonzero_cov++;
    return (p.old_a > a) ? p.old_a : ALPHA_W'(a);
  endfunction

  // Pixel driver: fed from the pending queue
  always @(posedge clk_i) begin
    pixel_t nxt;
    if (rst_ni) begin
      if (pix.valid && pix.ready) begin
        alpha_expected_q.push_back(capsule_alpha({pix.local_x, pix.local_y, pix.old_alpha}));
        pixels_sent++;
      end
      if (!pix.valid || pix.ready) begin
        if (pix_pending_q.size() > 0 &&
            !((idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH) &&
              $urandom_range(99) < idle_pct)) begin
          nxt = pix_pending_q.pop_front();
          pix.valid     <= 1'b1;
          pix.local_x   <= nxt.lx;
          pix.local_y   <= nxt.ly;
          pix.old_alpha <= nxt.old_a;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Alpha monitor: checks in order, drives ready with stalls and holds
  always @(posedge clk_i) begin
    logic [ALPHA_W-1:0] want;
    if (rst_ni) begin
      if (alpha.valid && alpha.ready) begin
        if (alpha_expected_q.size() == 0) begin
          $error("new_alpha: unexpected item, actual %0d", alpha.new_alpha);
          fail_count++;
        end else begin
          want = alpha_expected_q.pop_front();
          if (alpha.new_alpha !== want) begin
            $error("new_alpha: expected %0d, actual %0d", want, alpha.new_alpha);
            fail_count++;
          end
          alphas_checked++;
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stalled_cycles++;
        alpha.ready <= 1'b0;
      end else if ((idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH) &&
                   $urandom_range(99) < idle_pct) begin
        stalled_cycles++;
        alpha.ready <= 1'b0;
      end else begin
        alpha.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if ((pix.valid && pix.ready) || (alpha.valid && alpha.ready) ||
        (cfg.valid && cfg.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Register write; leaves valid high so back-to-back writes need no toggle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    case (idx)
      REG_START_X:    seg_sx   = longint'(signed'(val));
      REG_START_Y:    seg_sy   = longint'(signed'(val));
      REG_END_X:      seg_ex   = longint'(signed'(val));
      REG_END_Y:      seg_ey   = longint'(signed'(val));
      REG_EDGE_OUTER: seg_edge = longint'(val);
      REG_ORIGIN_X:   tile_ox  = longint'(signed'(val[ORG_W-1:0]));
      REG_ORIGIN_Y:   tile_oy  = longint'(signed'(val[ORG_W-1:0]));
      default: ;  // out-of-range index is dropped by the core
    endcase
  endtask

  task automatic set_capsule(int sx, int sy, int ex, int ey, int edge_r, int ox, int oy);
    write_reg(REG_START_X, CFG_DATA_W'(sx));
    write_reg(REG_START_Y, CFG_DATA_W'(sy));
    write_reg(REG_END_X, CFG_DATA_W'(ex));
    write_reg(REG_END_Y, CFG_DATA_W'(ey));
    write_reg(REG_EDGE_OUTER, CFG_DATA_W'(edge_r));
    write_reg(REG_ORIGIN_X, CFG_DATA_W'(ox));
    write_reg(REG_ORIGIN_Y, CFG_DATA_W'(oy));
    cfg.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Segment lying over the tile so most pixels see real coverage
  task automatic random_capsule();
    int ox, oy;
    ox = $urandom_range(65535) - 32768;
    oy = $urandom_range(65535) - 32768;
    if (ox > 32767 - 255) ox = 32767 - 255;
    if (oy > 32767 - 255) oy = 32767 - 255;
    set_capsule(((ox + $urandom_range(255)) << 8) + $urandom_range(255),
                ((oy + $urandom_range(255)) << 8) + $urandom_range(255),
                ((ox + $urandom_range(255)) << 8) + $urandom_range(255),
                ((oy + $urandom_range(255)) << 8) + $urandom_range(255),
                $urandom_range(40 << 8), ox, oy);
  endtask

  task automatic queue_random_pixels(int n);
    pixel_t p;
    for (int i = 0; i < n; i++) begin
      p.lx = $urandom_range(255);
      p.ly = $urandom_range(255);
      p.old_a = ($urandom_range(3) == 0) ? ALPHA_W'($urandom_range(255)) : '0;
      pix_pending_q.push_back(p);
    end
  endtask

  // Wait for every expected alpha, then let the pipeline settle
  task automatic drain();
    while (pix_pending_q.size() > 0 || alpha_expected_q.size() > 0 || pix.valid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    pix.valid = 1'b0; pix.local_x = '0; pix.local_y = '0; pix.old_alpha = '0;
    alpha.ready = 1'b0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
    seg_edge = 0; tile_ox = 0; tile_oy = 0;
    idle_mode = IDLE_NONE; idle_pct = 0;
    hold_token = 0; hold_seen = 0; hold_left = 0;
    fail_count = 0; pixels_sent = 0; alphas_checked = 0;
    nonzero_cov = 0; stalled_cycles = 0; quiet_cycles = 0;
    repeat (11) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: reset settings are a zero-length segment at the origin with
    // zero radius, so only old alpha survives
    pix_pending_q.push_back('{8'd0, 8'd0, 8'd0});
    pix_pending_q.push_back('{8'd255, 8'd255, 8'd255});
    pix_pending_q.push_back('{8'd0, 8'd255, 8'd128});
    drain();

    // Horizontal segment from (16,16) to (48,16), radius 2: start cap,
    // interior, end cap, full coverage and partial edge
    set_capsule(16 << 8, 16 << 8, 48 << 8, 16 << 8, 2 << 8, 0, 0);
    pix_pending_q.push_back('{8'd10, 8'd16, 8'd0});   // before the start
    pix_pending_q.push_back('{8'd30, 8'd16, 8'd0});   // on the line
    pix_pending_q.push_back('{8'd30, 8'd17, 8'd0});   // inside radius
    pix_pending_q.push_back('{8'd30, 8'd18, 8'd0});   // outside radius, no coverage
    pix_pending_q.push_back('{8'd60, 8'd16, 8'd0});   // past the end
    pix_pending_q.push_back('{8'd48, 8'd17, 8'd40});  // end cap, old alpha
    pix_pending_q.push_back('{8'd30, 8'd16, 8'd255}); // old alpha at max
    drain();

    // Zero-length segment with the widest radius, extremes of the tile
    set_capsule(100 << 8, 100 << 8, 100 << 8, 100 << 8, 24'hFFFFFF, 0, 0);
    write_reg(8'd7, 24'h123456);    // index out of range, must be ignored
    write_reg(8'd255, 24'hFFFFFF);
    cfg.valid <= 1'b0;
    @(posedge clk_i);
    pix_pending_q.push_back('{8'd0, 8'd0, 8'd0});
    pix_pending_q.push_back('{8'd255, 8'd255, 8'd0});
    drain();

    // Coordinate and origin extremes
    set_capsule(-8388608, 8388607, 8388607, -8388608, 24'hFFFFFF, -32768, 32767);
    pix_pending_q.push_back('{8'd0, 8'd0, 8'd0});
    pix_pending_q.push_back('{8'd255, 8'd0, 8'd1});
    drain();
    set_capsule(8388607, 8388607, -8388608, -8388608, 3 << 7, 32767, -32768);
    pix_pending_q.push_back('{8'd128, 8'd200, 8'd0});
    pix_pending_q.push_back('{8'd255, 8'd255, 8'd0});
    drain();

    // Random phases
    random_capsule();
    idle_mode = IDLE_NONE;
    queue_random_pixels(170);
    drain();

    random_capsule();
    idle_mode = IDLE_SEND; idle_pct = 63;
    queue_random_pixels(85);
    drain();                         // sender pauses until all results are in
    queue_random_pixels(85);
    drain();

    // Zero-length segment; long output hold fills the core
    set_capsule(128 << 8, 128 << 8, 128 << 8, 128 << 8, $urandom_range(64 << 8), 0, 0);
    idle_mode = IDLE_RECV; idle_pct = 63;
    hold_token++;
    queue_random_pixels(170);
    drain();

    random_capsule();
    idle_mode = IDLE_BOTH; idle_pct = 34;
    queue_random_pixels(170);
    drain();

    $display("Covered %0d pixels, %0d checked, %0d with segment coverage,",
             pixels_sent, alphas_checked, nonzero_cov);
    $display("under %0d output stall cycles across nine segment settings.", stalled_cycles);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/csc_pkg.sv
hw/rtl/csc_if.sv
hw/rtl/csc_front.sv
hw/rtl/csc_fifo.sv
hw/rtl/csc_back.sv
hw/rtl/capsule_segment_coverage_core.sv
bench/tb_capsule_segment_coverage_core.sv
